// ----- src/arp_cache_aging_table_top_assert.svh -----
// Assertion macros used by the checker file act_checker.sv.
`ifndef ARP_CACHE_AGING_TABLE_TOP_ASSERT_SVH
`define ARP_CACHE_AGING_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ACT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ACT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/act_pkg.sv -----
// Package with constants and types of the ARP cache table.
`timescale 1ns / 1ps
package act_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int IFACE_BITS_DEF = 4;
  localparam int MAX_RESULTS = 16;
  localparam logic [2:0] CMD_RESOLVE = 3'd0;
  localparam logic [2:0] CMD_REPLY = 3'd1;
  localparam logic [2:0] CMD_SET = 3'd2;
  localparam logic [2:0] CMD_TICK = 3'd3;
  localparam logic [2:0] CMD_CLEAN = 3'd4;
  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_STABLE = 3'd1;
  localparam logic [2:0] ST_REREQ1 = 3'd2;
  localparam logic [2:0] ST_REREQ2 = 3'd3;
  localparam logic [2:0] ST_STATIC = 3'd4;
  localparam logic [3:0] RS_HIT = 4'd0;
  localparam logic [3:0] RS_PENDING = 4'd1;
  localparam logic [3:0] RS_CREATED = 4'd2;
  localparam logic [3:0] RS_NOSRC = 4'd3;
  localparam logic [3:0] RS_FULL = 4'd4;
  localparam logic [3:0] RS_UPDATED = 4'd5;
  localparam logic [3:0] RS_ABSENT = 4'd6;
  localparam logic [3:0] RS_DONE = 4'd7;
  localparam logic [3:0] RS_REQUEST = 4'd8;
  localparam logic [1:0] REG_MAX_AGE = 2'd0;
  localparam logic [1:0] REG_REREQ_AGE = 2'd1;
  localparam logic [1:0] REG_PEND_AGE = 2'd2;
  localparam logic [6:0] AGE_MAX = 7'd127;
  localparam logic [6:0] RST_MAX_AGE = 7'd100;
  localparam logic [6:0] RST_REREQ_AGE = 7'd85;
  localparam logic [6:0] RST_PEND_AGE = 7'd5;
  typedef struct packed {
    logic [3:0] status;
    logic [47:0] found_mac;
    logic [31:0] request_ip;
    logic [3:0] request_iface;
    logic send_request;
    logic last;
  } result_t;
endpackage

// ----- src/arp_cache_aging_table_top.sv -----
// Top level of the ARP cache table with aging.
`timescale 1ns / 1ps
// Every slot lives in one RAM word that holds valid, ip, mac, interface, state and age.
// After reset a clearing pass writes all ENTRIES words, one per cycle, and s_tready stays
// low until the pass ends. Resolve, reply update and set entry read the table one
// slot per cycle and yield a single result word. Tick and cleanup handle each slot as
// a read and then a decide with write back. A tick yields one request word per pending
// entry that does not expire, at most 16. When a request word waits at the output, the
// walk stops at the next slot that yields a request word, and at its end, until that
// word leaves. The next command word is taken in the cycle after the last result word
// has left the output register.
module arp_cache_aging_table_top #(
  parameter int ENTRIES = act_pkg::ENTRIES_DEF,
  parameter int IFACE_BITS = act_pkg::IFACE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[2:0], ip_address[34:3], mac_address[82:35], iface_id[86:83],
  // new_state[89:87], source_found[90], zero to 95
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[3:0], found_mac[51:4], request_ip[83:52], request_iface[87:84],
  // send_request[88], zero to 95
  output logic [95:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);
  import act_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);
  localparam int DW = 1 + 32 + 48 + IFACE_BITS + 3 + 7;
  localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_SCAN = 3'd2, S_HDEC = 3'd3,
    S_WALK = 3'd4, S_DEC = 3'd5;

  logic [6:0] max_age, rerequest_age, max_pending_age;
  logic [2:0] state, state_next;
  logic [2:0] cmd;
  logic [31:0] ip;
  logic [47:0] mac;
  logic [IFACE_BITS-1:0] ifc;
  logic [2:0] nst;
  logic src;
  logic [CW-1:0] idx, idx_next;
  logic rd_pend;
  logic [AW-1:0] rd_idx;
  logic hit, have_free, hit_take, free_take;
  logic [AW-1:0] hit_idx, free_idx;
  logic [47:0] hit_mac;
  logic [IFACE_BITS-1:0] hit_ifc;
  logic [2:0] hit_st;
  logic [6:0] hit_age;
  logic have_req, have_req_next;
  logic [31:0] req_ip, req_ip_next;
  logic [IFACE_BITS-1:0] req_ifc, req_ifc_next;
  logic [RW-1:0] nreq, nreq_next;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic r_valid;
  logic [31:0] r_ip;
  logic [47:0] r_mac;
  logic [IFACE_BITS-1:0] r_ifc;
  logic [2:0] r_st, st_step;
  logic [6:0] r_age, age_inc;
  logic expire, new_req, accept, out_free;
  result_t res, res_next;
  logic res_valid, res_valid_next;

  assign {r_valid, r_ip, r_mac, r_ifc, r_st, r_age} = rdata;
  assign age_inc = (r_age < AGE_MAX) ? r_age + 7'd1 : r_age;
  assign st_step = (r_st == ST_REREQ1) ? ST_REREQ2 : (r_st == ST_REREQ2) ? ST_STABLE : r_st;
  assign expire = (age_inc >= max_age) || (r_st == ST_PENDING && age_inc >= max_pending_age);
  assign new_req = !expire && (r_st == ST_PENDING) && (nreq < RW'(MAX_RESULTS));
  assign raddr = idx[AW-1:0];

  act_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE) && !res_valid;
  assign accept = s_tvalid && s_tready;
  assign out_free = !res_valid || m_tready;
  assign m_tvalid = res_valid;
  assign m_tlast = res.last;
  assign m_tdata = {7'd0, res.send_request, res.request_iface, res.request_ip,
                    res.found_mac, res.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= RST_MAX_AGE;
      rerequest_age <= RST_REREQ_AGE;
      max_pending_age <= RST_PEND_AGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_AGE: max_age <= cfg_data;
        REG_REREQ_AGE: rerequest_age <= cfg_data;
        REG_PEND_AGE: max_pending_age <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic result_t mk(input logic [3:0] st, input logic lst);
    result_t r;
    r = '0;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic result_t mk_req(input logic [31:0] rip,
                                     input logic [IFACE_BITS-1:0] rif, input logic lst);
    result_t r;
    r = '0;
    r.status = RS_REQUEST;
    r.request_ip = rip;
    r.request_iface = 4'(rif);
    r.send_request = 1'b1;
    r.last = lst;
    return r;
  endfunction

  always_comb begin
    state_next = state;
    idx_next = idx;
    res_next = res;
    res_valid_next = res_valid && !m_tready;
    have_req_next = have_req;
    req_ip_next = req_ip;
    req_ifc_next = req_ifc;
    nreq_next = nreq;
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = '0;
    hit_take = 1'b0;
    free_take = 1'b0;
    case (state)
      S_INIT: begin
        we = 1'b1;
        idx_next = idx + CW'(1);
        if (idx == CW'(ENTRIES - 1)) begin
          idx_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          have_req_next = 1'b0;
          nreq_next = '0;
          case (s_tdata[2:0])
            CMD_RESOLVE, CMD_REPLY, CMD_SET: state_next = S_SCAN;
            CMD_TICK, CMD_CLEAN: state_next = S_WALK;
            default: begin
              res_next = mk(RS_DONE, 1'b1);
              res_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_pend) begin
          if (r_valid && r_ip == ip && !hit) hit_take = 1'b1;
          if (!r_valid && !have_free) free_take = 1'b1;
        end
        if (idx < CW'(ENTRIES)) begin
          idx_next = idx + CW'(1);
        end else begin
          state_next = S_HDEC;
        end
      end
      S_HDEC: begin
        state_next = S_IDLE;
        res_valid_next = 1'b1;
        waddr = hit ? hit_idx : free_idx;
        case (cmd)
          CMD_RESOLVE: begin
            if (hit) begin
              if (hit_st != ST_PENDING) begin
                res_next = mk(RS_HIT, 1'b1);
                res_next.found_mac = hit_mac;
                if (hit_age >= rerequest_age) begin
                  we = 1'b1;
                  wdata = {1'b1, ip, hit_mac, hit_ifc, ST_REREQ1, hit_age};
                  if (src) begin
                    res_next.send_request = 1'b1;
                    res_next.request_ip = ip;
                    res_next.request_iface = 4'(ifc);
                  end
                end
              end else begin
                res_next = mk(RS_PENDING, 1'b1);
              end
            end else if (!src) begin
              res_next = mk(RS_NOSRC, 1'b1);
            end else if (!have_free) begin
              res_next = mk(RS_FULL, 1'b1);
            end else begin
              we = 1'b1;
              wdata = {1'b1, ip, 48'hFFFF_FFFF_FFFF, ifc, ST_PENDING, 7'd0};
              res_next = mk(RS_CREATED, 1'b1);
            end
          end
          CMD_REPLY: begin
            if (hit) begin
              we = 1'b1;
              wdata = {1'b1, ip, mac, ifc, ST_STABLE, 7'd0};
              res_next = mk(RS_UPDATED, 1'b1);
            end else begin
              res_next = mk(RS_ABSENT, 1'b1);
            end
          end
          CMD_SET: begin
            if (hit) begin
              we = 1'b1;
              wdata = {1'b1, ip, mac, ifc, nst, 7'd0};
              res_next = mk(RS_UPDATED, 1'b1);
            end else if (!have_free) begin
              res_next = mk(RS_FULL, 1'b1);
            end else begin
              we = 1'b1;
              wdata = {1'b1, ip, mac, ifc, nst, 7'd0};
              res_next = mk(RS_CREATED, 1'b1);
            end
          end
          default: res_next = mk(RS_DONE, 1'b1);
        endcase
      end
      S_WALK: begin
        if (idx < CW'(ENTRIES)) begin
          state_next = S_DEC;
        end else if (out_free) begin
          state_next = S_IDLE;
          res_valid_next = 1'b1;
          if (have_req) begin
            res_next = mk_req(req_ip, req_ifc, 1'b1);
          end else begin
            res_next = mk(RS_DONE, 1'b1);
          end
        end
      end
      S_DEC: begin
        if (cmd == CMD_CLEAN) begin
          if (r_valid && r_ifc == ifc) begin
            we = 1'b1;
            wdata = {1'b0, r_ip, r_mac, r_ifc, r_st, r_age};
          end
          idx_next = idx + CW'(1);
          state_next = S_WALK;
        end else if (!r_valid || r_st == ST_STATIC) begin
          idx_next = idx + CW'(1);
          state_next = S_WALK;
        end else if (!new_req || !have_req || out_free) begin
          we = 1'b1;
          wdata = {!expire, r_ip, r_mac, r_ifc, st_step, age_inc};
          idx_next = idx + CW'(1);
          state_next = S_WALK;
          if (new_req) begin
            nreq_next = nreq + RW'(1);
            req_ip_next = r_ip;
            req_ifc_next = r_ifc;
            have_req_next = 1'b1;
            if (have_req) begin
              res_next = mk_req(req_ip, req_ifc, 1'b0);
              res_valid_next = 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      res <= '0;
      res_valid <= 1'b0;
      have_req <= 1'b0;
      req_ip <= '0;
      req_ifc <= '0;
      nreq <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      res <= res_next;
      res_valid <= res_valid_next;
      have_req <= have_req_next;
      req_ip <= req_ip_next;
      req_ifc <= req_ifc_next;
      nreq <= nreq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit <= 1'b0;
      have_free <= 1'b0;
    end else if (accept) begin
      cmd <= s_tdata[2:0];
      ip <= s_tdata[34:3];
      mac <= s_tdata[82:35];
      ifc <= IFACE_BITS'(s_tdata[86:83]);
      nst <= (s_tdata[89:87] > ST_STATIC) ? ST_STATIC : s_tdata[89:87];
      src <= s_tdata[90];
      rd_pend <= 1'b0;
      hit <= 1'b0;
      have_free <= 1'b0;
    end else if (state == S_SCAN) begin
      rd_pend <= (idx < CW'(ENTRIES));
      rd_idx <= idx[AW-1:0];
      if (hit_take) begin
        hit <= 1'b1;
        hit_idx <= rd_idx;
        hit_mac <= r_mac;
        hit_ifc <= r_ifc;
        hit_st <= r_st;
        hit_age <= r_age;
      end
      if (free_take) begin
        have_free <= 1'b1;
        free_idx <= rd_idx;
      end
    end
  end
endmodule

// ----- src/act_ram.sv -----
// Generic single-port-write RAM with a registered read.
`timescale 1ns / 1ps
module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/act_checker.sv -----
// Port checker for the ARP cache table, bound to the top level.
`timescale 1ns / 1ps
`include "arp_cache_aging_table_top_assert.svh"
module act_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tlast
);
  import act_pkg::*;

  `ACT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tlast, m_tdata}))
  `ACT_ASSERT_IMP(a_no_take_busy, m_tvalid, !s_tready)
  `ACT_ASSERT_IMP(a_mac_only_hit, m_tvalid && m_tdata[3:0] != RS_HIT, m_tdata[51:4] == 48'd0)
  `ACT_ASSERT_IMP(a_req_flag, m_tvalid && m_tdata[3:0] == RS_REQUEST, m_tdata[88])
endmodule

bind arp_cache_aging_table_top act_checker u_act_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ----- dv/tb.sv -----
// Testbench for the ARP cache table with aging: self-checking scoreboard and stimulus.
`timescale 1ns / 1ps
module tb;
  import act_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = SLOTS + 12;

  class ArpTableScoreboard;
    bit          slot_valid[SLOTS];
    logic [31:0] slot_ip[SLOTS];
    logic [47:0] slot_mac[SLOTS];
    logic [3:0]  slot_iface[SLOTS];
    logic [2:0]  slot_state[SLOTS];
    logic [6:0]  slot_age[SLOTS];
    logic [6:0]  max_age = RST_MAX_AGE;
    logic [6:0]  rereq_age = RST_REREQ_AGE;
    logic [6:0]  pend_age = RST_PEND_AGE;
    result_t     expected_q[$];
    int          errors = 0;

    function void write_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        REG_MAX_AGE:   max_age = val;
        REG_REREQ_AGE: rereq_age = val;
        REG_PEND_AGE:  pend_age = val;
        default: ;
      endcase
    endfunction

    function int find_ip(logic [31:0] ip);
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_ip[i] == ip) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < SLOTS; i++)
        if (!slot_valid[i]) return i;
      return -1;
    endfunction

    function void fill(int i, logic [31:0] ip, logic [47:0] mac, logic [3:0] ifc,
                       logic [2:0] st);
      slot_valid[i] = 1;
      slot_ip[i] = ip;
      slot_mac[i] = mac;
      slot_iface[i] = ifc;
      slot_state[i] = st;
      slot_age[i] = '0;
    endfunction

    function void push(logic [3:0] status, logic [47:0] mac = '0, logic [31:0] rip = '0,
                       logic [3:0] rif = '0, logic send = 1'b0);
      result_t r;
      r.status = status;
      r.found_mac = mac;
      r.request_ip = rip;
      r.request_iface = rif;
      r.send_request = send;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Works out the result words of one accepted command word.
    function void note_word(logic [95:0] w);
      logic [2:0]  cmd;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [3:0]  ifc;
      logic [2:0]  nst;
      logic        src;
      logic        send;
      int          i;
      int          n;
      cmd = w[2:0];
      ip = w[34:3];
      mac = w[82:35];
      ifc = w[86:83];
      nst = (w[89:87] > ST_STATIC) ? ST_STATIC : w[89:87];
      src = w[90];
      n = 0;
      case (cmd)
        CMD_RESOLVE: begin
          i = find_ip(ip);
          if (i >= 0) begin
            if (slot_state[i] != ST_PENDING) begin
              send = 1'b0;
              if (slot_age[i] >= rereq_age) begin
                slot_state[i] = ST_REREQ1;
                send = src;
              end
              push(RS_HIT, slot_mac[i], send ? ip : '0, send ? ifc : '0, send);
            end else begin
              push(RS_PENDING);
            end
          end else if (!src) begin
            push(RS_NOSRC);
          end else begin
            i = find_free();
            if (i < 0) begin
              push(RS_FULL);
            end else begin
              fill(i, ip, '1, ifc, ST_PENDING);
              push(RS_CREATED);
            end
          end
        end
        CMD_REPLY: begin
          i = find_ip(ip);
          if (i >= 0) begin
            fill(i, ip, mac, ifc, ST_STABLE);
            push(RS_UPDATED);
          end else begin
            push(RS_ABSENT);
          end
        end
        CMD_SET: begin
          i = find_ip(ip);
          if (i >= 0) begin
            fill(i, ip, mac, ifc, nst);
            push(RS_UPDATED);
          end else begin
            i = find_free();
            if (i < 0) begin
              push(RS_FULL);
            end else begin
              fill(i, ip, mac, ifc, nst);
              push(RS_CREATED);
            end
          end
        end
        CMD_TICK: begin
          for (int k = 0; k < SLOTS; k++) begin
            if (!slot_valid[k] || slot_state[k] == ST_STATIC) continue;
            if (slot_age[k] < AGE_MAX) slot_age[k]++;
            if (slot_age[k] >= max_age ||
                (slot_state[k] == ST_PENDING && slot_age[k] >= pend_age)) begin
              slot_valid[k] = 0;
            end else if (slot_state[k] == ST_REREQ1) begin
              slot_state[k] = ST_REREQ2;
            end else if (slot_state[k] == ST_REREQ2) begin
              slot_state[k] = ST_STABLE;
            end else if (slot_state[k] == ST_PENDING && n < MAX_RESULTS) begin
              push(RS_REQUEST, '0, slot_ip[k], slot_iface[k], 1'b1);
              n++;
            end
          end
          if (n == 0) push(RS_DONE);
        end
        CMD_CLEAN: begin
          for (int k = 0; k < SLOTS; k++)
            if (slot_valid[k] && slot_iface[k] == ifc) slot_valid[k] = 0;
          push(RS_DONE);
        end
        default: push(RS_DONE);
      endcase
      expected_q[$].last = 1'b1;
    endfunction

    function void check_word(logic [95:0] d, logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h last %b", $realtime, d, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d[3:0] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.status, d[3:0]);
        errors++;
      end
      if (d[51:4] !== e.found_mac) begin
        $display("%0t: found_mac expected %h actual %h", $realtime, e.found_mac, d[51:4]);
        errors++;
      end
      if (d[83:52] !== e.request_ip) begin
        $display("%0t: request_ip expected %h actual %h", $realtime, e.request_ip,
                 d[83:52]);
        errors++;
      end
      if (d[87:84] !== e.request_iface) begin
        $display("%0t: request_iface expected %0d actual %0d", $realtime,
                 e.request_iface, d[87:84]);
        errors++;
      end
      if (d[88] !== e.send_request) begin
        $display("%0t: send_request expected %b actual %b", $realtime, e.send_request,
                 d[88]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $realtime, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  ArpTableScoreboard sb;
  bit          no_idle;
  int          hold_req;
  int          hold_seen;
  int          cycles;
  logic [31:0] ip_pool[24];

  arp_cache_aging_table_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_word(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
  end

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [31:0] ip, logic [47:0] mac,
                           logic [3:0] ifc, logic [2:0] nst, logic src);
    s_tdata <= {5'b0, src, nst, ifc, mac, ip, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk iff s_tready);
    if (!no_idle && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [6:0] a, logic [6:0] b, logic [6:0] c);
    write_reg(REG_MAX_AGE, a);
    write_reg(REG_REREQ_AGE, b);
    write_reg(REG_PEND_AGE, c);
  endtask

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(99) < 85) ? ip_pool[$urandom_range(23)] : $urandom;
  endfunction

  task automatic random_words(int count);
    int r;
    logic [2:0] cmd;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 35) cmd = CMD_RESOLVE;
      else if (r < 50) cmd = CMD_REPLY;
      else if (r < 70) cmd = CMD_SET;
      else if (r < 90) cmd = CMD_TICK;
      else if (r < 95) cmd = CMD_CLEAN;
      else cmd = 3'($urandom_range(5, 7));
      send_word(cmd, pick_ip(), 48'({$urandom, $urandom}), 4'($urandom_range(15)),
                3'($urandom_range(7)), ($urandom_range(99) < 80));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 0;
    hold_seen = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int k = 2; k < 24; k++) ip_pool[k] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(CMD_SET, 32'h0, 48'h0, 4'd0, ST_STABLE, 1'b0);
    send_word(CMD_SET, 32'hFFFF_FFFF, '1, 4'd15, ST_STATIC, 1'b1);
    send_word(CMD_SET, 32'h0A00_0001, 48'h0123_4567_89AB, 4'd3, ST_REREQ1, 1'b0);
    send_word(CMD_SET, 32'h0A00_0002, 48'hFEDC_BA98_7654, 4'd3, ST_REREQ2, 1'b0);
    send_word(CMD_SET, 32'h0A00_0003, 48'h1, 4'd7, 3'd7, 1'b0);
    send_word(CMD_SET, 32'h0A00_0004, 48'h2, 4'd7, ST_PENDING, 1'b0);
    send_word(CMD_RESOLVE, 32'h0, '0, 4'd1, 3'd0, 1'b1);
    send_word(CMD_RESOLVE, 32'hFFFF_FFFF, '0, 4'd15, 3'd0, 1'b1);
    send_word(CMD_RESOLVE, 32'h0A00_0004, '0, 4'd0, 3'd0, 1'b1);
    send_word(CMD_RESOLVE, 32'hC0A8_0001, '0, 4'd2, 3'd0, 1'b0);
    send_word(CMD_RESOLVE, 32'hC0A8_0001, '0, 4'd2, 3'd0, 1'b1);
    send_word(CMD_REPLY, 32'hC0A8_0001, 48'hAAAA_5555_AAAA, 4'd9, 3'd0, 1'b0);
    send_word(CMD_REPLY, 32'hC0A8_0002, 48'h5555_AAAA_5555, 4'd9, 3'd0, 1'b0);
    send_word(CMD_RESOLVE, 32'hC0A8_0003, '0, 4'd5, 3'd0, 1'b1);
    send_word(CMD_TICK, '0, '0, 4'd0, 3'd0, 1'b0);
    send_word(CMD_TICK, '0, '0, 4'd0, 3'd0, 1'b0);
    send_word(CMD_CLEAN, '0, '0, 4'd7, 3'd0, 1'b0);
    send_word(3'd5, '1, '1, 4'd15, 3'd7, 1'b1);
    send_word(3'd6, '0, '0, 4'd0, 3'd0, 1'b0);
    send_word(3'd7, '0, '0, 4'd0, 3'd0, 1'b0);
    drain();

    // Everything ages out or asks for a re-request at once.
    set_regs(7'd1, 7'd1, 7'd1);
    send_word(CMD_SET, 32'h0A00_0001, 48'h3, 4'd1, ST_STABLE, 1'b0);
    send_word(CMD_TICK, '0, '0, 4'd0, 3'd0, 1'b0);
    random_words(40);
    drain();

    set_regs(7'd127, 7'd127, 7'd127);
    no_idle = 1'b1;
    random_words(50);
    no_idle = 1'b0;
    hold_req = hold_req + 1;
    random_words(30);
    drain();

    set_regs(7'($urandom_range(8, 40)), 7'($urandom_range(1, 10)),
             7'($urandom_range(2, 8)));
    random_words(50);
    drain();

    set_regs(7'd0, 7'd0, 7'd0);
    random_words(15);
    drain();

    set_regs(RST_MAX_AGE, RST_REREQ_AGE, RST_PEND_AGE);
    random_words(15);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
